// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("itp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ITP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("itp assertion failed");

`endif

// ===== rtl/itp_pkg.sv =====
// Package with constants and types for the IPv6/TCP header parser.
`timescale 1ns / 1ps
`default_nettype none
package itp_pkg;

	localparam int unsigned MAX_FRAME_BYTES   = 65536;
	localparam int unsigned LINK_HEADER_BYTES = 14;
	localparam int unsigned IPV6_BASE_BYTES   = 40;
	localparam int unsigned EXT_UNIT_SHIFT    = 3;
	localparam int unsigned TCP_FLAGS_BYTE    = 13;
	localparam int unsigned TCP_PORT_BYTES    = 4;

	localparam int unsigned OFF_W = 16;
	localparam int unsigned POS_W = OFF_W + 1;

	localparam logic [OFF_W-1:0] OFF_MAX        = OFF_W'(MAX_FRAME_BYTES - 1);
	localparam logic [OFF_W-1:0] OFF_BASE_NH    = OFF_W'(LINK_HEADER_BYTES + 6);
	localparam logic [OFF_W-1:0] OFF_SRC_ADDR   = OFF_W'(LINK_HEADER_BYTES + 8);
	localparam logic [OFF_W-1:0] OFF_DST_ADDR   = OFF_W'(LINK_HEADER_BYTES + 24);
	localparam logic [OFF_W-1:0] OFF_BASE_LAST  = OFF_W'(LINK_HEADER_BYTES + IPV6_BASE_BYTES - 1);
	localparam logic [OFF_W-1:0] OFF_FIRST_HDR  = OFF_W'(LINK_HEADER_BYTES + IPV6_BASE_BYTES);
	localparam logic [POS_W-1:0] REACH_LIMIT    =
		POS_W'(MAX_FRAME_BYTES - 1 - TCP_FLAGS_BYTE);

	localparam logic [2:0] PH_BASE    = 3'd0;
	localparam logic [2:0] PH_EXT     = 3'd1;
	localparam logic [2:0] PH_TCP     = 3'd2;
	localparam logic [2:0] PH_DONE    = 3'd3;
	localparam logic [2:0] PH_UNREACH = 3'd4;

	localparam logic [7:0] NH_TCP   = 8'd6;
	localparam logic [7:0] NH_UDP   = 8'd17;
	localparam logic [7:0] NH_ICMP6 = 8'd58;
	localparam logic [7:0] NH_NONE  = 8'd59;

	localparam logic [2:0] KIND_TCP   = 3'd0;
	localparam logic [2:0] KIND_NONE  = 3'd1;
	localparam logic [2:0] KIND_ICMP6 = 3'd2;
	localparam logic [2:0] KIND_UDP   = 3'd3;
	localparam logic [2:0] KIND_TRUNC = 3'd4;

	localparam int unsigned TDATA_W    = 296;
	localparam int unsigned TUSER_W    = 3;
	localparam int unsigned SRC_HI_LSB = 0;
	localparam int unsigned SRC_LO_LSB = 64;
	localparam int unsigned DST_HI_LSB = 128;
	localparam int unsigned DST_LO_LSB = 192;
	localparam int unsigned SPORT_LSB  = 256;
	localparam int unsigned DPORT_LSB  = 272;
	localparam int unsigned SYN_BIT    = 288;

	typedef struct packed {
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic        syn;
		logic [2:0]  kind;
	} itp_result_t;

endpackage
`default_nettype wire

// ===== rtl/ipv6_tcp_header_parser_unit.sv =====
// Top level of the IPv6/TCP header parser: input stage, walker and result register.
// Takes one frame byte per clock and walks the IPv6 base header and any
// extension headers up to TCP, UDP, ICMPv6 or no-next-header. Each byte is
// taken into an input register and applied to the walker from there; the
// frame summary is loaded into the result register, which drives the master
// side, as the byte marked tlast leaves the input register. A new byte is
// accepted every cycle; s_axis_tready drops only while a last byte waits in
// the input register behind a result that has not been taken.
`timescale 1ns / 1ps
`default_nettype none
module ipv6_tcp_header_parser_unit
	import itp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [7:0]         s_axis_tdata,  // [7:0] frame_byte
	input  wire logic               s_axis_tlast,
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	// [63:0] source_addr_high, [127:64] source_addr_low, [191:128] dest_addr_high,
	// [255:192] dest_addr_low, [271:256] source_port, [287:272] dest_port,
	// [288] syn_seen, [295:289] zero
	output logic [TDATA_W-1:0]      m_axis_tdata,
	output logic [TUSER_W-1:0]      m_axis_tuser   // [2:0] transport_kind
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              out_free;
	logic              advance;
	itp_result_t       result;

	logic              m_valid_q;
	logic [TDATA_W-1:0] m_data_q;
	logic [TUSER_W-1:0] m_user_q;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign advance       = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
			last_s1  <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
			byte_s1  <= s_axis_tdata;
			last_s1  <= s_axis_tlast;
		end
	end

	itp_walker u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.frame_byte (byte_s1),
		.last_byte  (last_s1),
		.result     (result)
	);

	// load the summary on the last byte, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			m_user_q  <= '0;
		end else if (advance && last_s1) begin
			m_valid_q <= 1'b1;
			m_data_q  <= {7'd0, result.syn, result.dst_port, result.src_port,
				result.dst_lo, result.dst_hi, result.src_lo, result.src_hi};
			m_user_q  <= result.kind;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule
`default_nettype wire

// ===== rtl/itp_walker.sv =====
// Header walker: offset tracking, field capture and frame summary.
`timescale 1ns / 1ps
`default_nettype none
module itp_walker
	import itp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  frame_byte,
	input  wire logic        last_byte,
	output itp_result_t      result
);

	logic [OFF_W-1:0] off_q, off_d;
	logic [7:0]       pnh_q, pnh_d;
	logic [OFF_W-1:0] hso_q, hso_d;
	logic [2:0]       phase_q, phase_d;
	logic [127:0]     src_q, src_d;
	logic [127:0]     dst_q, dst_d;
	logic [31:0]      ports_q, ports_d;
	logic             syn_q, syn_d;

	logic             enter;
	logic [POS_W-1:0] enter_start;
	logic [POS_W-1:0] st_x;
	logic [POS_W-1:0] off_x;
	logic [2:0]       kind;

	always_comb begin
		st_x        = POS_W'(hso_q);
		off_x       = POS_W'(off_q);
		off_d       = off_q;
		pnh_d       = pnh_q;
		hso_d       = hso_q;
		phase_d     = phase_q;
		src_d       = src_q;
		dst_d       = dst_q;
		ports_d     = ports_q;
		syn_d       = syn_q;
		enter       = 1'b0;
		enter_start = POS_W'(OFF_FIRST_HDR);

		case (phase_q)
			PH_BASE: begin
				if (off_q == OFF_BASE_NH) begin
					pnh_d = frame_byte;
				end else if (off_q >= OFF_SRC_ADDR && off_q < OFF_DST_ADDR) begin
					src_d = {src_q[119:0], frame_byte};
				end else if (off_q >= OFF_DST_ADDR && off_q < OFF_FIRST_HDR) begin
					dst_d = {dst_q[119:0], frame_byte};
				end
				if (off_q == OFF_BASE_LAST) begin
					enter = 1'b1;
				end
			end
			PH_EXT: begin
				if (off_x == st_x) begin
					pnh_d = frame_byte;
				end else if (off_x == st_x + POS_W'(1)) begin
					enter       = 1'b1;
					enter_start = st_x + ((POS_W'(frame_byte) + POS_W'(1)) << EXT_UNIT_SHIFT);
				end
			end
			PH_TCP: begin
				if (off_x >= st_x && off_x < st_x + POS_W'(TCP_PORT_BYTES)) begin
					ports_d = {ports_q[23:0], frame_byte};
				end else if (off_x == st_x + POS_W'(TCP_FLAGS_BYTE)) begin
					syn_d   = frame_byte[1];
					phase_d = PH_DONE;
				end
			end
			default: begin
			end
		endcase

		if (enter) begin
			if (pnh_q == NH_UDP || pnh_q == NH_ICMP6 || pnh_q == NH_NONE) begin
				phase_d = PH_DONE;
			end else if (enter_start >= REACH_LIMIT) begin
				phase_d = PH_UNREACH;
			end else begin
				hso_d   = enter_start[OFF_W-1:0];
				phase_d = (pnh_q == NH_TCP) ? PH_TCP : PH_EXT;
			end
		end

		if (off_q != OFF_MAX) begin
			off_d = off_q + OFF_W'(1);
		end

		kind = KIND_TRUNC;
		if (phase_d == PH_DONE) begin
			case (pnh_d)
				NH_TCP:   kind = KIND_TCP;
				NH_NONE:  kind = KIND_NONE;
				NH_ICMP6: kind = KIND_ICMP6;
				NH_UDP:   kind = KIND_UDP;
				default:  kind = KIND_TRUNC;
			endcase
		end

		result.src_hi   = src_d[127:64];
		result.src_lo   = src_d[63:0];
		result.dst_hi   = dst_d[127:64];
		result.dst_lo   = dst_d[63:0];
		result.src_port = (kind == KIND_TCP) ? ports_d[31:16] : 16'd0;
		result.dst_port = (kind == KIND_TCP) ? ports_d[15:0] : 16'd0;
		result.syn      = (kind == KIND_TCP) ? syn_d : 1'b0;
		result.kind     = kind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			pnh_q   <= '0;
			hso_q   <= OFF_FIRST_HDR;
			phase_q <= PH_BASE;
			src_q   <= '0;
			dst_q   <= '0;
			ports_q <= '0;
			syn_q   <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				off_q   <= '0;
				pnh_q   <= '0;
				hso_q   <= OFF_FIRST_HDR;
				phase_q <= PH_BASE;
				src_q   <= '0;
				dst_q   <= '0;
				ports_q <= '0;
				syn_q   <= 1'b0;
			end else begin
				off_q   <= off_d;
				pnh_q   <= pnh_d;
				hso_q   <= hso_d;
				phase_q <= phase_d;
				src_q   <= src_d;
				dst_q   <= dst_d;
				ports_q <= ports_d;
				syn_q   <= syn_d;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/itp_checker.sv =====
// Port-level checker for the IPv6/TCP header parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module itp_checker
	import itp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	input  wire logic               s_axis_tready,
	input  wire logic [7:0]         s_axis_tdata,
	input  wire logic               s_axis_tlast,
	input  wire logic               m_axis_tvalid,
	input  wire logic               m_axis_tready,
	input  wire logic [TDATA_W-1:0] m_axis_tdata,
	input  wire logic [TUSER_W-1:0] m_axis_tuser
);

	logic in_last_acc;
	logic [SYN_BIT-SPORT_LSB:0] tcp_part;

	assign in_last_acc = s_axis_tvalid && s_axis_tready && s_axis_tlast;
	assign tcp_part    = m_axis_tdata[SYN_BIT:SPORT_LSB];

	`ITP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
	`ITP_ASSERT_NOW(a_kind_range, clk, arst_n, m_axis_tvalid, m_axis_tuser <= KIND_TRUNC)
	`ITP_ASSERT_NOW(a_tcp_only, clk, arst_n, m_axis_tvalid && m_axis_tuser != KIND_TCP,
		tcp_part == '0)
	`ITP_ASSERT_NOW(a_out_after_last, clk, arst_n, $rose(m_axis_tvalid),
		$past(in_last_acc, 2) && s_axis_tdata == s_axis_tdata)

endmodule

bind ipv6_tcp_header_parser_unit itp_checker u_itp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
